// ===== hw/rtl/tmc_pkg.sv =====
// Shared types and constants for the trimmed-mean consensus update block.
// Used by tmc_store, tmc_div and trimmed_mean_consensus_update_top.
package tmc_pkg;

  localparam int DATA_W     = 32;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] NCOUNT_RST = 5'd7;

  typedef logic [2:0][DATA_W-1:0] vec3_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NCOUNT = 3'd0,
    CFG_TRIM   = 3'd1,
    CFG_INIT_X = 3'd2,
    CFG_INIT_Y = 3'd3,
    CFG_INIT_Z = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_COUNT,
    S_CNT_TAIL,
    S_PIVOT,
    S_PIVOT_W,
    S_SCAN,
    S_SCAN_TAIL,
    S_ACC,
    S_DIV_GO,
    S_DIV_WAIT
  } state_t;

endpackage

// ===== hw/rtl/tmc_store.sv =====
// Neighbor position store: one synchronous memory of x/y/z words.
// One write port, one read port with registered data. Depends on tmc_pkg.
module tmc_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  tmc_pkg::vec3_t  wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output tmc_pkg::vec3_t  rd_data
);
  import tmc_pkg::*;

  vec3_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/tmc_div.sv =====
// Serial signed divider, one quotient bit per cycle, truncates toward zero.
// Divides a wide signed sum by a small unsigned count. Depends on tmc_pkg.
module tmc_div #(
  parameter int DW = 38,
  parameter int VW = 5
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [DW-1:0]      dividend,
  input  logic [VW-1:0]             divisor,
  output logic                      done,
  output logic [tmc_pkg::DATA_W-1:0] quot
);
  import tmc_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;
  logic          neg_r;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_sub;
  logic          ge;

  assign rem_sh  = {rem_r, q_r[DW-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DW-1];
      q_r   <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
      q_r   <= {q_r[DW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = neg_r ? (DATA_W'(0) - q_r[DATA_W-1:0]) : q_r[DATA_W-1:0];

endmodule

// ===== hw/rtl/trimmed_mean_consensus_update_top.sv =====
// Trimmed-mean consensus update: neighbor positions enter one per start pulse
// and are written to the store, with busy staying low. The pulse that completes
// a round raises busy for the reduction: a count pass, then a pass ranking every
// stored value against all others through the single store read port, then the
// serial dividers. out_valid pulses for one cycle with the new position; the
// receiver cannot stall, so take it then.
module trimmed_mean_consensus_update_top #(
  parameter int MAX_NEIGHBORS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [tmc_pkg::DATA_W-1:0] in_nbr_x,
  input  logic signed [tmc_pkg::DATA_W-1:0] in_nbr_y,
  input  logic signed [tmc_pkg::DATA_W-1:0] in_nbr_z,
  output logic                            out_valid,
  output logic signed [tmc_pkg::DATA_W-1:0] out_new_x,
  output logic signed [tmc_pkg::DATA_W-1:0] out_new_y,
  output logic signed [tmc_pkg::DATA_W-1:0] out_new_z,
  output logic [tmc_pkg::CNT_W-1:0]         out_kept_x_count,
  input  logic                            cfg_we,
  input  logic [tmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tmc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import tmc_pkg::*;

  localparam int IW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int CW = $clog2(MAX_NEIGHBORS + 1);
  localparam int VW = $clog2(MAX_NEIGHBORS + 2);
  localparam int KW = (VW > CNT_W) ? VW : CNT_W;
  localparam int SW = DATA_W + 1 + $clog2(MAX_NEIGHBORS + 1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] ncount_r;
  logic [CNT_W-1:0] trim_r;
  vec3_t            own_r;
  logic [IW-1:0]    rc_r;
  logic [CW-1:0]    n_r;
  logic [IW-1:0]    a_r;
  logic [IW-1:0]    i_r;
  vec3_t            piv_r;
  logic [CW-1:0]    hi_r   [3];
  logic [CW-1:0]    lo_r   [3];
  logic [CW-1:0]    rank_r [3];
  logic signed [SW-1:0] sum_r [3];
  logic             rd_vld_r;
  logic [IW-1:0]    rd_addr_r;
  logic             out_valid_r;
  vec3_t            out_r;
  logic [CNT_W-1:0] out_kept_r;

  logic             accept;
  logic             round_end;
  logic [KW-1:0]    nc_k;
  logic [CW-1:0]    n_eff;
  logic [CW-1:0]    rc_p1;
  logic [IW-1:0]    nm1;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  vec3_t            rd_data;
  vec3_t            wr_data;
  logic [KW-1:0]    drop_hi [3];
  logic [KW-1:0]    drop_lo [3];
  logic [KW-1:0]    kcnt    [3];
  logic             keep    [3];
  logic             div_done [3];
  logic [DATA_W-1:0] div_q  [3];

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign wr_data   = {in_nbr_z, in_nbr_y, in_nbr_x};

  // Saturate round size to 1..MAX_NEIGHBORS
  always_comb begin
    nc_k = KW'(ncount_r);
    if (nc_k == '0) begin
      n_eff = CW'(1);
    end else if (nc_k > KW'(MAX_NEIGHBORS)) begin
      n_eff = CW'(MAX_NEIGHBORS);
    end else begin
      n_eff = nc_k[CW-1:0];
    end
  end

  assign rc_p1     = CW'(rc_r) + CW'(1);
  assign round_end = rc_p1 >= n_eff;
  assign nm1       = IW'(n_r - CW'(1));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      drop_hi[k] = (KW'(hi_r[k]) > KW'(trim_r)) ? KW'(trim_r) : KW'(hi_r[k]);
      drop_lo[k] = (KW'(lo_r[k]) > KW'(trim_r)) ? KW'(trim_r) : KW'(lo_r[k]);
      kcnt[k]    = KW'(n_r) - drop_hi[k] - drop_lo[k] + KW'(1);
      // Rank within the stable sorted order decides whether the pivot survives
      keep[k]    = (KW'(rank_r[k]) >= drop_lo[k]) &&
                   (KW'(rank_r[k]) < (KW'(n_r) - drop_hi[k]));
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (accept && round_end) state_nxt = S_COUNT;
      S_COUNT:     if (a_r == nm1) state_nxt = S_CNT_TAIL;
      S_CNT_TAIL:  state_nxt = S_PIVOT;
      S_PIVOT:     state_nxt = S_PIVOT_W;
      S_PIVOT_W:   state_nxt = S_SCAN;
      S_SCAN:      if (a_r == nm1) state_nxt = S_SCAN_TAIL;
      S_SCAN_TAIL: state_nxt = S_ACC;
      S_ACC:       state_nxt = (i_r == nm1) ? S_DIV_GO : S_PIVOT;
      S_DIV_GO:    state_nxt = S_DIV_WAIT;
      S_DIV_WAIT:  if (div_done[0]) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign rd_en   = (state_r == S_COUNT) || (state_r == S_PIVOT) || (state_r == S_SCAN);
  assign rd_addr = (state_r == S_PIVOT) ? i_r : a_r;

  tmc_store #(
    .DEPTH (MAX_NEIGHBORS),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (rc_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    tmc_div #(
      .DW (SW),
      .VW (VW)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (state_r == S_DIV_GO),
      .dividend (sum_r[g]),
      .divisor  (kcnt[g][VW-1:0]),
      .done     (div_done[g]),
      .quot     (div_q[g])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncount_r    <= NCOUNT_RST;
      trim_r      <= '0;
      own_r       <= '0;
      rc_r        <= '0;
      a_r         <= '0;
      i_r         <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= rd_en;
      out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NCOUNT: ncount_r <= cfg_wdata[CNT_W-1:0];
          CFG_TRIM:   trim_r   <= cfg_wdata[CNT_W-1:0];
          CFG_INIT_X: own_r[0] <= cfg_wdata;
          CFG_INIT_Y: own_r[1] <= cfg_wdata;
          CFG_INIT_Z: own_r[2] <= cfg_wdata;
          default: ;
        endcase
      end

      if (accept) begin
        rc_r <= round_end ? '0 : IW'(rc_p1);
      end

      if (state_r == S_COUNT || state_r == S_SCAN) begin
        a_r <= (a_r == nm1) ? '0 : a_r + 1'b1;
      end else begin
        a_r <= '0;
      end

      if (state_r == S_IDLE) begin
        i_r <= '0;
      end else if (state_r == S_ACC) begin
        i_r <= (i_r == nm1) ? '0 : i_r + 1'b1;
      end

      if (state_r == S_DIV_WAIT && div_done[0]) begin
        own_r       <= {div_q[2], div_q[1], div_q[0]};
        out_valid_r <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr;
    if (accept && round_end) begin
      n_r <= n_eff;
      for (int k = 0; k < 3; k++) begin
        hi_r[k]  <= '0;
        lo_r[k]  <= '0;
        sum_r[k] <= SW'($signed(own_r[k]));
      end
    end
    if (rd_vld_r && (state_r == S_COUNT || state_r == S_CNT_TAIL)) begin
      for (int k = 0; k < 3; k++) begin
        if ($signed(rd_data[k]) > $signed(own_r[k])) hi_r[k] <= hi_r[k] + 1'b1;
        if ($signed(rd_data[k]) < $signed(own_r[k])) lo_r[k] <= lo_r[k] + 1'b1;
      end
    end
    if (state_r == S_PIVOT_W) begin
      piv_r <= rd_data;
      for (int k = 0; k < 3; k++) begin
        rank_r[k] <= '0;
      end
    end
    if (rd_vld_r && (state_r == S_SCAN || state_r == S_SCAN_TAIL)) begin
      for (int k = 0; k < 3; k++) begin
        if (($signed(rd_data[k]) < $signed(piv_r[k])) ||
            ((rd_data[k] == piv_r[k]) && (rd_addr_r < i_r))) begin
          rank_r[k] <= rank_r[k] + 1'b1;
        end
      end
    end
    if (state_r == S_ACC) begin
      for (int k = 0; k < 3; k++) begin
        if (keep[k]) sum_r[k] <= sum_r[k] + SW'($signed(piv_r[k]));
      end
    end
    if (state_r == S_DIV_WAIT && div_done[0]) begin
      out_r      <= {div_q[2], div_q[1], div_q[0]};
      out_kept_r <= CNT_W'(kcnt[0]);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_x        = out_r[0];
  assign out_new_y        = out_r[1];
  assign out_new_z        = out_r[2];
  assign out_kept_x_count = out_kept_r;

endmodule

// ===== test/tb_trimmed_mean_consensus_update_top.sv =====
// Testbench for trimmed_mean_consensus_update_top: directed and random neighbor
// streams checked against an in-bench trimmed-mean predictor. Depends on tmc_pkg.
`timescale 1ns / 100ps

module tb_trimmed_mean_consensus_update_top;
  import tmc_pkg::*;

  localparam int MAXN = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic [CNT_W-1:0]         kept_x;
  } position_t;

  logic clk, rst_n, start, busy;
  logic signed [DATA_W-1:0] in_nbr_x, in_nbr_y, in_nbr_z;
  logic out_valid;
  logic signed [DATA_W-1:0] out_new_x, out_new_y, out_new_z;
  logic [CNT_W-1:0] out_kept_x_count;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predictor state
  int unsigned round_size_reg, trim_reg, held;
  logic signed [DATA_W-1:0] own_pos[3];
  logic signed [DATA_W-1:0] nbr_mem[3][MAXN];
  position_t pending_positions[$];

  int errors;
  int idle_pct;
  int quiet_cycles;

  trimmed_mean_consensus_update_top #(.MAX_NEIGHBORS(MAXN)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_nbr_x(in_nbr_x), .in_nbr_y(in_nbr_y), .in_nbr_z(in_nbr_z),
    .out_valid(out_valid), .out_new_x(out_new_x), .out_new_y(out_new_y),
    .out_new_z(out_new_z), .out_kept_x_count(out_kept_x_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [DATA_W-1:0] trimmed_mean(
      int axis, int unsigned n, logic signed [DATA_W-1:0] own, output int unsigned kept);
    logic signed [DATA_W-1:0] v[MAXN];
    logic signed [DATA_W-1:0] t;
    int unsigned above, below, d_hi, d_lo;
    longint sum;
    int j;
    above = 0;
    below = 0;
    for (int i = 0; i < n; i++) begin
      v[i] = nbr_mem[axis][i];
      if (v[i] > own) above++;
      if (v[i] < own) below++;
    end
    for (int i = 1; i < n; i++) begin
      t = v[i];
      j = i;
      while (j > 0 && v[j-1] > t) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = t;
    end
    d_hi = (above > trim_reg) ? trim_reg : above;
    d_lo = (below > trim_reg) ? trim_reg : below;
    sum = longint'(own);
    for (int i = d_lo; i < n - d_hi; i++) sum += longint'(v[i]);
    kept = n - d_hi - d_lo + 1;
    return DATA_W'(sum / longint'(kept));
  endfunction

  function automatic void predict_round(logic signed [DATA_W-1:0] nx,
      logic signed [DATA_W-1:0] ny, logic signed [DATA_W-1:0] nz);
    int unsigned n, kx, ky, kz;
    position_t p;
    n = (round_size_reg < 1) ? 1 : (round_size_reg > MAXN) ? MAXN : round_size_reg;
    if (held < MAXN) begin
      nbr_mem[0][held] = nx;
      nbr_mem[1][held] = ny;
      nbr_mem[2][held] = nz;
    end
    held++;
    if (held < n) return;
    held = 0;
    p.x = trimmed_mean(0, n, own_pos[0], kx);
    p.y = trimmed_mean(1, n, own_pos[1], ky);
    p.z = trimmed_mean(2, n, own_pos[2], kz);
    p.kept_x = CNT_W'(kx);
    own_pos[0] = p.x;
    own_pos[1] = p.y;
    own_pos[2] = p.z;
    pending_positions = {pending_positions, p};
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    position_t e;
    if (rst_n && out_valid) begin
      if (pending_positions.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h kept=%0d", $time,
                 out_new_x, out_new_y, out_new_z, out_kept_x_count);
        errors++;
      end else begin
        e = pending_positions.pop_front();
        if (out_new_x !== e.x) begin
          $display("%0t: new_x expected %h actual %h", $time, e.x, out_new_x);
          errors++;
        end
        if (out_new_y !== e.y) begin
          $display("%0t: new_y expected %h actual %h", $time, e.y, out_new_y);
          errors++;
        end
        if (out_new_z !== e.z) begin
          $display("%0t: new_z expected %h actual %h", $time, e.z, out_new_z);
          errors++;
        end
        if (out_kept_x_count !== e.kept_x) begin
          $display("%0t: kept_x_count expected %0d actual %0d", $time, e.kept_x,
                   out_kept_x_count);
          errors++;
        end
      end
    end
    if ((start && !busy) || out_valid || !rst_n) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // start stays high between back-to-back requests; idle cycles and drain drop it
  task automatic send_neighbor(logic signed [DATA_W-1:0] nx,
      logic signed [DATA_W-1:0] ny, logic signed [DATA_W-1:0] nz);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_nbr_x <= nx;
    in_nbr_y <= ny;
    in_nbr_z <= nz;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_round(nx, ny, nz);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_positions.size() != 0 && guard < WATCHDOG_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    // a non-completing item may leave the block still reducing
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_NCOUNT: round_size_reg = val[CNT_W-1:0];
      CFG_TRIM:   trim_reg = val[CNT_W-1:0];
      CFG_INIT_X: own_pos[0] = val;
      CFG_INIT_Y: own_pos[1] = val;
      CFG_INIT_Z: own_pos[2] = val;
      default: ;
    endcase
  endtask

  function automatic logic signed [DATA_W-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return DATA_W'($signed($urandom_range(64)) - 32) <<< 16;
      2: return DATA_W'($signed($urandom_range(20)) - 10);
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  task automatic test_directed_extremes;
    idle_pct = 0;
    // reset defaults: rounds of seven, no trim
    send_neighbor(32'h7fffffff, 32'h80000000, 0);
    send_neighbor(32'h80000000, 32'h7fffffff, 1);
    repeat (5) send_neighbor(32'h7fffffff, 32'h7fffffff, -1);
    write_reg(CFG_TRIM, 2);
    write_reg(CFG_INIT_X, 32'h0001_0000);
    write_reg(CFG_INIT_Y, 32'h8000_0000);
    write_reg(CFG_INIT_Z, 32'h7fff_ffff);
    // equal values kept, trim clamps on sparse side
    for (int i = 0; i < 7; i++) send_neighbor(32'h0001_0000, i, -i);
    // round size zero acts as one
    write_reg(CFG_NCOUNT, 0);
    send_neighbor(32'hffff_ffff, 5, -5);
    // trim larger than any side
    write_reg(CFG_TRIM, 31);
    write_reg(CFG_NCOUNT, 3);
    send_neighbor(-3, 3, 100);
    send_neighbor(10, -10, 0);
    send_neighbor(0, 0, 0);
  endtask

  task automatic test_round_lowered_midway;
    write_reg(CFG_TRIM, 1);
    write_reg(CFG_NCOUNT, 6);
    for (int i = 0; i < 4; i++) send_neighbor($urandom, $urandom, $urandom);
    write_reg(CFG_NCOUNT, 2);
    send_neighbor($urandom, $urandom, $urandom);
    // ignored register index
    drain();
    cfg_we <= 1'b1;
    cfg_index <= 3'd7;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_random_phase(int pct, int items, int unsigned nmax, int fill_max);
    int mode;
    idle_pct = pct;
    for (int k = 0; k < items; k++) begin
      if (held == 0 && $urandom_range(9) == 0) begin
        write_reg(CFG_NCOUNT, $urandom_range(nmax, 1));
        write_reg(CFG_TRIM, $urandom_range(fill_max));
        if ($urandom_range(3) == 0) write_reg(CFG_INIT_X, $urandom);
        if ($urandom_range(3) == 0) write_reg(CFG_INIT_Y, $urandom);
        if ($urandom_range(3) == 0) write_reg(CFG_INIT_Z, $urandom);
      end
      mode = $urandom_range(3);
      send_neighbor(rand_coord(mode), rand_coord(mode), rand_coord(mode));
    end
  endtask

  task automatic test_large_rounds;
    idle_pct = 26;
    write_reg(CFG_NCOUNT, 31);
    write_reg(CFG_TRIM, 16);
    repeat (2 * MAXN) send_neighbor($urandom, $urandom, $urandom);
    write_reg(CFG_NCOUNT, MAXN);
    write_reg(CFG_TRIM, 4);
    repeat (MAXN) send_neighbor(rand_coord(1), rand_coord(2), rand_coord(0));
  endtask

  initial begin
    errors = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_nbr_x = '0;
    in_nbr_y = '0;
    in_nbr_z = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    round_size_reg = NCOUNT_RST;
    trim_reg = 0;
    held = 0;
    own_pos[0] = 0;
    own_pos[1] = 0;
    own_pos[2] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_round_lowered_midway();
    test_random_phase(0, 180, 8, 4);
    drain();
    test_random_phase(47, 180, 8, 4);
    test_random_phase(47, 160, 5, 3);
    test_random_phase(26, 120, 6, 6);
    test_large_rounds();

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_positions.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== trimmed_mean_consensus_update_top.f =====
hw/rtl/tmc_pkg.sv
hw/rtl/tmc_store.sv
hw/rtl/tmc_div.sv
hw/rtl/trimmed_mean_consensus_update_top.sv
test/tb_trimmed_mean_consensus_update_top.sv
